@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/srt2d_pkg.sv @@
// shared types and constants for the 2d scale rotate translate block
package srt2d_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_SHIFT_X    = 3'd0,
        REG_SHIFT_Y    = 3'd1,
        REG_TURN_ANGLE = 3'd2,
        REG_GAIN_X     = 3'd3,
        REG_GAIN_Y     = 3'd4
    } reg_index_t;

    // coefficient set handed from the trig unit to the datapath
    typedef struct packed {
        logic signed [15:0] cos_val;
        logic signed [15:0] sin_val;
    } trig_t;

    // request carried through the queue
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
    } point_t;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
        logic signed [33:0] r;
        begin
            unique case (idx)
                5'd0:  r = 34'sh020000000;
                5'd1:  r = 34'sh012E4051E;
                5'd2:  r = 34'sh009FB385B;
                5'd3:  r = 34'sh0051111D4;
                5'd4:  r = 34'sh0028B0D43;
                5'd5:  r = 34'sh00145D7E1;
                5'd6:  r = 34'sh000A2F61E;
                5'd7:  r = 34'sh000517C55;
                5'd8:  r = 34'sh00028BE53;
                5'd9:  r = 34'sh000145F2F;
                5'd10: r = 34'sh0000A2F98;
                5'd11: r = 34'sh0000517CC;
                5'd12: r = 34'sh000028BE6;
                5'd13: r = 34'sh0000145F3;
                5'd14: r = 34'sh00000A2FA;
                5'd15: r = 34'sh00000517D;
                5'd16: r = 34'sh0000028BE;
                5'd17: r = 34'sh00000145F;
                5'd18: r = 34'sh000000A30;
                5'd19: r = 34'sh000000518;
                5'd20: r = 34'sh00000028C;
                5'd21: r = 34'sh000000146;
                5'd22: r = 34'sh0000000A3;
                5'd23: r = 34'sh000000051;
                default: r = 34'sh0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ design/srt2d_trig.sv @@
// sequential cordic that turns the angle register into cos and sin in q1.15
module srt2d_trig #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          turn_angle,
    input  logic                 restart,
    output srt2d_pkg::trig_t     trig,
    output logic                 ready
);
    localparam int NSTEP = (CORDIC_STEPS < srt2d_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : srt2d_pkg::ATAN_ENTRIES;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]         step_reg, step_next;
    logic               run_reg, run_next, flip_reg, flip_next;
    logic               ready_reg, ready_next;
    srt2d_pkg::trig_t   trig_reg, trig_next;
    logic [15:0]        a_fold;
    logic               fold;
    logic signed [33:0] xs, ys, at, xr, yr;
    logic signed [18:0] cr, sr;

    always_comb
    begin
        fold   = (turn_angle >= 16'h4000) && (turn_angle < 16'hC000);
        a_fold = fold ? (turn_angle - 16'h8000) : turn_angle;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = srt2d_pkg::atan_turn(step_reg);
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        step_next = step_reg; run_next = run_reg; flip_next = flip_reg;
        ready_next = ready_reg; trig_next = trig_reg;
        // final rounding of the rotated vector
        xr = (x_reg + 34'sd16384) >>> 15;
        yr = (y_reg + 34'sd16384) >>> 15;
        cr = flip_reg ? -xr[18:0] : xr[18:0];
        sr = flip_reg ? -yr[18:0] : yr[18:0];
        if (restart)
        begin
            x_next = srt2d_pkg::CORDIC_X0;
            y_next = '0;
            z_next = {{2{a_fold[15]}}, a_fold, 16'h0};
            step_next = '0;
            run_next = 1'b1;
            flip_next = fold;
            ready_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (step_reg == 5'(NSTEP))
            begin
                run_next = 1'b0;
                ready_next = 1'b1;
                trig_next.cos_val = (cr > 19'sd32767) ? 16'sd32767 :
                                    (cr < -19'sd32768) ? -16'sd32768 : cr[15:0];
                trig_next.sin_val = (sr > 19'sd32767) ? 16'sd32767 :
                                    (sr < -19'sd32768) ? -16'sd32768 : sr[15:0];
            end
            else
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                step_next = step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            ready_reg <= 1'b0;
            step_reg  <= '0;
            flip_reg  <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            ready_reg <= ready_next;
            step_reg  <= step_next;
            flip_reg  <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        trig_reg <= trig_next;
    end

    assign trig  = trig_reg;
    assign ready = ready_reg;
endmodule

@@ design/srt2d_front.sv @@
// request front end: small fifo that parks points until coefficients are ready
module srt2d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srt2d_pkg::point_t  push_data,
    input  logic               pop,
    output srt2d_pkg::point_t  head,
    output logic               not_empty,
    output logic               full
);
    srt2d_pkg::point_t mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop)  rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != 3'd0);
    assign full      = (cnt_reg == 3'd4);
endmodule

@@ design/srt2d_back.sv @@
// pipelined matrix datapath: coefficient products, point products, sum, shift add and saturate
module srt2d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  srt2d_pkg::point_t  pt,
    input  srt2d_pkg::trig_t   trig,
    input  logic signed [15:0] gain_x,
    input  logic signed [15:0] gain_y,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic               clipped
);
    logic [3:0] v_reg;
    // coefficient products, stage 1
    logic signed [31:0] cgx_reg, sgy_reg, sgx_reg, cgy_reg;
    logic signed [31:0] px1_reg, py1_reg;
    // point products, stage 2
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    // row sums, stage 3
    logic signed [63:0] rx_reg, ry_reg;
    logic signed [41:0] tx, ty;
    logic signed [31:0] ox_reg, oy_reg;
    logic               clip_reg;
    logic               hx, hy;

    always_comb
    begin
        tx = 42'($signed(rx_reg[63:23])) + 42'(shift_x);
        ty = 42'($signed(ry_reg[63:23])) + 42'(shift_y);
        hx = (tx > 42'sd2147483647) || (tx < -42'sd2147483648);
        hy = (ty > 42'sd2147483647) || (ty < -42'sd2147483648);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else        v_reg <= {v_reg[2:0], go};
    end

    always_ff @(posedge clk)
    begin
        cgx_reg <= 32'(trig.cos_val) * 32'(gain_x);
        sgy_reg <= 32'(trig.sin_val) * 32'(gain_y);
        sgx_reg <= 32'(trig.sin_val) * 32'(gain_x);
        cgy_reg <= 32'(trig.cos_val) * 32'(gain_y);
        px1_reg <= pt.px;
        py1_reg <= pt.py;
        p0_reg  <= 64'(cgx_reg) * 64'(px1_reg);
        p1_reg  <= 64'(sgy_reg) * 64'(py1_reg);
        p2_reg  <= 64'(sgx_reg) * 64'(px1_reg);
        p3_reg  <= 64'(cgy_reg) * 64'(py1_reg);
        rx_reg  <= p0_reg - p1_reg;
        ry_reg  <= p2_reg + p3_reg;
        ox_reg  <= hx ? (tx[41] ? 32'sh80000000 : 32'sh7FFFFFFF) : tx[31:0];
        oy_reg  <= hy ? (ty[41] ? 32'sh80000000 : 32'sh7FFFFFFF) : ty[31:0];
        clip_reg <= hx || hy;
    end

    assign done    = v_reg[3];
    assign out_x   = ox_reg;
    assign out_y   = oy_reg;
    assign clipped = clip_reg;
endmodule

@@ design/scale_rotate_translate_2d.sv @@
// top level of the 2d scale rotate translate block
//  channel   | handshake          | payload
//  request   | start / busy       | point_x, point_y
//  result    | done (one cycle)   | out_x, out_y, clipped
//  config    | cfg_we, cfg_index  | cfg_data
// one request per cycle once coefficients are valid; requests pass
// through the queue and the four-stage multiply pipeline.
// after reset or a turn_angle write the cordic runs again;
// busy is high while it runs and queued requests wait.
// results cannot be stalled; done marks each for one cycle.
module scale_rotate_translate_2d #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic               clipped,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic signed [31:0] shift_x_reg, shift_y_reg;
    logic [15:0]        angle_reg;
    logic signed [15:0] gain_x_reg, gain_y_reg;
    logic               restart_reg;
    srt2d_pkg::trig_t   trig;
    logic               trig_ready, q_ne, q_full, pop;
    srt2d_pkg::point_t  head, in_pt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            angle_reg   <= '0;
            gain_x_reg  <= 16'sd256;
            gain_y_reg  <= 16'sd256;
            restart_reg <= 1'b1;
        end
        else
        begin
            restart_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    srt2d_pkg::REG_SHIFT_X:    shift_x_reg <= cfg_data;
                    srt2d_pkg::REG_SHIFT_Y:    shift_y_reg <= cfg_data;
                    srt2d_pkg::REG_TURN_ANGLE:
                    begin
                        angle_reg   <= cfg_data[15:0];
                        restart_reg <= 1'b1;
                    end
                    srt2d_pkg::REG_GAIN_X:     gain_x_reg <= cfg_data[15:0];
                    srt2d_pkg::REG_GAIN_Y:     gain_y_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign in_pt.px = point_x;
    assign in_pt.py = point_y;
    assign busy = q_full || !trig_ready;
    assign pop  = q_ne && trig_ready && !restart_reg;

    srt2d_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_trig (
        .clk(clk), .rst_n(rst_n), .turn_angle(angle_reg), .restart(restart_reg),
        .trig(trig), .ready(trig_ready)
    );

    srt2d_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_data(in_pt),
        .pop(pop), .head(head), .not_empty(q_ne), .full(q_full)
    );

    srt2d_back u_back (
        .clk(clk), .rst_n(rst_n), .go(pop), .pt(head), .trig(trig),
        .gain_x(gain_x_reg), .gain_y(gain_y_reg),
        .shift_x(shift_x_reg), .shift_y(shift_y_reg),
        .done(done), .out_x(out_x), .out_y(out_y), .clipped(clipped)
    );
endmodule

@@ design/srt2d_checker.sv @@
// port-level checker for the 2d scale rotate translate block
`include "assert_macros.svh"
module srt2d_port_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done,
    input logic clipped,
    input logic cfg_we,
    input logic [2:0] cfg_index
);
    `CHK_IMPLY(a_busy_known, clk, rst_n, 1'b1, !$isunknown(busy), "busy unknown")
    `CHK_IMPLY(a_done_known, clk, rst_n, 1'b1, !$isunknown(done), "done unknown")
    `CHK_IMPLY(a_clip_known, clk, rst_n, done, !$isunknown(clipped), "clipped unknown on result")
    // the write sets the restart register, which clears the cordic ready register, so busy follows
    `CHK_NEXT(a_angle_busy, clk, rst_n, cfg_we && cfg_index == srt2d_pkg::REG_TURN_ANGLE, ##1 busy, "angle write not busy")
endmodule

bind scale_rotate_translate_2d srt2d_port_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done),
    .clipped(clipped), .cfg_we(cfg_we), .cfg_index(cfg_index)
);
